@@ sv/avt_pkg.sv @@
// Shared types and constants for the affine vertex transform.
`default_nettype none

package avt_pkg;

  // Number of matrix rows, and so of parallel lanes
  localparam int unsigned NumRows = 3;

  // Configuration register file
  localparam int unsigned NumCfgRegs = 2 * NumRows;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 64;

  // Q16.16 coordinate width and internal widths
  localparam int unsigned CoordW = 32;
  localparam int unsigned ProdW = 2 * CoordW;
  localparam int unsigned FracBits = 16;
  // three products shifted down by 16 plus the translation term
  localparam int unsigned SumW = ProdW - FracBits + 2;

  // Register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_ROW0_FIRST  = 3'd0,
    REG_ROW0_SECOND = 3'd1,
    REG_ROW1_FIRST  = 3'd2,
    REG_ROW1_SECOND = 3'd3,
    REG_ROW2_FIRST  = 3'd4,
    REG_ROW2_SECOND = 3'd5
  } cfg_reg_e;

  // Reset values: identity matrix, zero translation
  localparam logic [CfgDataW-1:0] CfgReset [NumCfgRegs] = '{
    64'h0000_0000_0001_0000,
    64'h0000_0000_0000_0000,
    64'h0001_0000_0000_0000,
    64'h0000_0000_0000_0000,
    64'h0000_0000_0000_0000,
    64'h0000_0000_0001_0000
  };

  // Saturation limits
  localparam logic [CoordW-1:0] PosLimit = 32'h7FFF_FFFF;
  localparam logic [CoordW-1:0] NegLimit = 32'h8000_0000;

  // Stage enables from the pipeline control to each lane
  typedef struct packed {
    logic en_mul;
    logic en_sum;
  } lane_ctl_t;

  // One lane's clamped result
  typedef struct packed {
    logic [CoordW-1:0] val;
    logic              sat;
  } lane_res_t;

endpackage

`default_nettype wire

@@ sv/affine_vertex_transform.sv @@
// Top level of the affine vertex transform: config registers, lanes, pipeline control.
//
// Transforms one Q16.16 point (x, y, z) per beat by a 3x4 affine matrix held in
// six 64-bit registers (reset to identity). Three row lanes run in parallel; each
// multiplies, floor-shifts by 16, adds the translation and clamps to 32 bits, and
// the output stage ORs the clamp flags into tuser. Throughput is one point per
// clock while the sink is ready; an accepted point passes through the multiply,
// sum and output registers in turn. Each stage moves independently, so input
// is still accepted while a result waits as long as an earlier stage is empty.
// The user must write registers through cfg_we_i / cfg_idx_i / cfg_data_i only
// while the block is idle, not enforced here; writes past the last index are dropped.
`default_nettype none

module affine_vertex_transform
  import avt_pkg::*;
(
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      cfg_we_i,
  input  wire logic [CfgIdxW-1:0]        cfg_idx_i,
  input  wire logic [CfgDataW-1:0]       cfg_data_i,
  input  wire logic                      s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  input  wire logic [NumRows*CoordW-1:0] s_axis_tdata_i,  // in_x, in_y, in_z
  output logic                           m_axis_tvalid_o,
  input  wire logic                      m_axis_tready_i,
  output logic [NumRows*CoordW-1:0]      m_axis_tdata_o,  // out_x, out_y, out_z
  output logic                           m_axis_tuser_o   // saturated
);

  logic [CfgDataW-1:0] coef_q [NumCfgRegs];
  logic                mul_vld_q, mul_vld_d;
  logic                sum_vld_q, sum_vld_d;
  logic                adv_mul, adv_sum, adv_out;
  lane_ctl_t           ctl;
  lane_res_t           res [NumRows];

  // Coefficient registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumCfgRegs; i++) begin
        coef_q[i] <= CfgReset[i];
      end
    end else if (cfg_we_i) begin
      for (int i = 0; i < NumCfgRegs; i++) begin
        if (cfg_idx_i == CfgIdxW'(i)) begin
          coef_q[i] <= cfg_data_i;
        end
      end
    end
  end

  // Stage advance: a stage loads when it is empty or the next one takes its beat
  assign adv_sum = !sum_vld_q || adv_out;
  assign adv_mul = !mul_vld_q || adv_sum;
  assign s_axis_tready_o = adv_mul;

  assign ctl.en_mul = adv_mul;
  assign ctl.en_sum = adv_sum;

  assign mul_vld_d = adv_mul ? s_axis_tvalid_i : mul_vld_q;
  assign sum_vld_d = adv_sum ? mul_vld_q : sum_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_vld_q <= 1'b0;
      sum_vld_q <= 1'b0;
    end else begin
      mul_vld_q <= mul_vld_d;
      sum_vld_q <= sum_vld_d;
    end
  end

  // One lane per matrix row
  for (genvar r = 0; r < NumRows; r++) begin : g_lane
    avt_lane u_lane (
      .clk_i        (clk_i),
      .coef_first_i (coef_q[2*r]),
      .coef_second_i(coef_q[2*r+1]),
      .x_i          (s_axis_tdata_i[0*CoordW +: CoordW]),
      .y_i          (s_axis_tdata_i[1*CoordW +: CoordW]),
      .z_i          (s_axis_tdata_i[2*CoordW +: CoordW]),
      .ctl_i        (ctl),
      .res_o        (res[r])
    );
  end

  // Merge and output register
  avt_merge u_merge (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .valid_i        (sum_vld_q),
    .res_i          (res),
    .ready_o        (adv_out),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o)
  );

endmodule

`default_nettype wire

@@ sv/avt_lane.sv @@
// One matrix row: three multipliers, a sum stage and a clamp.
`default_nettype none

module avt_lane
  import avt_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic [CfgDataW-1:0] coef_first_i,
  input  wire logic [CfgDataW-1:0] coef_second_i,
  input  wire logic [CoordW-1:0]   x_i,
  input  wire logic [CoordW-1:0]   y_i,
  input  wire logic [CoordW-1:0]   z_i,
  input  wire lane_ctl_t           ctl_i,
  output lane_res_t                res_o
);

  logic signed [CoordW-1:0] cx, cy, cz, tr;
  logic signed [CoordW-1:0] px, py, pz;
  logic signed [ProdW-1:0]  prod_x_d, prod_y_d, prod_z_d;
  logic signed [ProdW-1:0]  prod_x_q, prod_y_q, prod_z_q;
  logic signed [SumW-1:0]   sum_d, sum_q;
  logic                     ovf;

  assign cx = $signed(coef_first_i[CoordW-1:0]);
  assign cy = $signed(coef_first_i[CfgDataW-1:CoordW]);
  assign cz = $signed(coef_second_i[CoordW-1:0]);
  assign tr = $signed(coef_second_i[CfgDataW-1:CoordW]);
  assign px = $signed(x_i);
  assign py = $signed(y_i);
  assign pz = $signed(z_i);

  // Stage 1: exact signed products
  assign prod_x_d = cx * px;
  assign prod_y_d = cy * py;
  assign prod_z_d = cz * pz;

  always_ff @(posedge clk_i) begin
    if (ctl_i.en_mul) begin
      prod_x_q <= prod_x_d;
      prod_y_q <= prod_y_d;
      prod_z_q <= prod_z_d;
    end
  end

  // Stage 2: floor-shift each product, add translation
  assign sum_d = $signed(SumW'(prod_x_q >>> FracBits))
               + $signed(SumW'(prod_y_q >>> FracBits))
               + $signed(SumW'(prod_z_q >>> FracBits))
               + $signed({{(SumW-CoordW){tr[CoordW-1]}}, tr});

  always_ff @(posedge clk_i) begin
    if (ctl_i.en_sum) begin
      sum_q <= sum_d;
    end
  end

  // Clamp: out of range when the bits above bit 31 are not all sign copies
  assign ovf = !((&sum_q[SumW-1:CoordW-1]) || !(|sum_q[SumW-1:CoordW-1]));

  always_comb begin
    res_o.sat = ovf;
    if (!ovf) begin
      res_o.val = sum_q[CoordW-1:0];
    end else if (sum_q[SumW-1]) begin
      res_o.val = NegLimit;
    end else begin
      res_o.val = PosLimit;
    end
  end

endmodule

`default_nettype wire

@@ sv/avt_merge.sv @@
// Output stage: gathers the lane results, merges the flags, holds the beat.
`default_nettype none

module avt_merge
  import avt_pkg::*;
(
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     valid_i,
  input  wire lane_res_t                res_i [NumRows],
  output logic                          ready_o,
  output logic                          m_axis_tvalid_o,
  input  wire logic                     m_axis_tready_i,
  output logic [NumRows*CoordW-1:0]     m_axis_tdata_o,  // out_x, out_y, out_z
  output logic                          m_axis_tuser_o   // saturated
);

  logic                      valid_q, valid_d;
  logic [NumRows*CoordW-1:0] data_q, data_d;
  logic                      sat_q, sat_d;

  assign ready_o = !valid_q || m_axis_tready_i;

  // Pack components, OR the clamp flags
  always_comb begin
    sat_d = 1'b0;
    for (int r = 0; r < NumRows; r++) begin
      data_d[r*CoordW +: CoordW] = res_i[r].val;
      sat_d = sat_d | res_i[r].sat;
    end
  end

  assign valid_d = ready_o ? valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
      sat_q  <= sat_d;
    end
  end

  assign m_axis_tvalid_o = valid_q;
  assign m_axis_tdata_o  = data_q;
  assign m_axis_tuser_o  = sat_q;

endmodule

`default_nettype wire

@@ sv/avt_checker.sv @@
// Port-level checks for the affine vertex transform, bound to the top level.
`default_nettype none

module avt_checker
  import avt_pkg::*;
(
  input wire logic                      clk_i,
  input wire logic                      rst_ni,
  input wire logic                      s_axis_tready_o,
  input wire logic                      m_axis_tvalid_o,
  input wire logic                      m_axis_tready_i,
  input wire logic [NumRows*CoordW-1:0] m_axis_tdata_o,
  input wire logic                      m_axis_tuser_o
);

  // A stalled output beat holds its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("output beat changed while stalled");

  // An empty output register or a ready sink frees the whole pipeline
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!m_axis_tvalid_o || m_axis_tready_i) |-> s_axis_tready_o)
    else $error("input stalled with free output stage");

  // A flagged beat carries at least one clamped component
  a_sat_clamped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o |->
      (m_axis_tdata_o[31:0] == PosLimit) || (m_axis_tdata_o[31:0] == NegLimit) ||
      (m_axis_tdata_o[63:32] == PosLimit) || (m_axis_tdata_o[63:32] == NegLimit) ||
      (m_axis_tdata_o[95:64] == PosLimit) || (m_axis_tdata_o[95:64] == NegLimit))
    else $error("saturation flag without a clamped component");

  // Output is empty at the first edge after reset is released
  a_no_early_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !m_axis_tvalid_o)
    else $error("output valid right after reset");

endmodule

bind affine_vertex_transform avt_checker u_avt_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .s_axis_tready_o(s_axis_tready_o),
  .m_axis_tvalid_o(m_axis_tvalid_o),
  .m_axis_tready_i(m_axis_tready_i),
  .m_axis_tdata_o (m_axis_tdata_o),
  .m_axis_tuser_o (m_axis_tuser_o)
);

`default_nettype wire
